[rtl/srbc_pkg.sv]
// Shared constants, types and helpers for the segment ranking block.
// Used by the channel interfaces, controller, datapath and top level.
package srbc_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int COUNT_BITS   = 24;
	localparam int ID_W         = $clog2(MAX_SEGMENTS);
	localparam int SEG_IN_W     = 8;
	localparam int NSEG_W       = 6;
	localparam int RANK_ID_W    = 6;
	localparam int OUT_COUNT_W  = 24;
	localparam int KEY_W        = COUNT_BITS + ID_W;
	localparam logic [NSEG_W-1:0] NSEG_RESET = NSEG_W'(63);

	typedef logic [ID_W-1:0]       seg_idx_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [KEY_W-1:0]      rank_key_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_SCAN,
		ST_TAIL,
		ST_EMIT,
		ST_CLEAR
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic in_take;
		logic scan_clr;
		logic scan_en;
		logic emit;
		logic hist_clear;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;
		logic found;
		logic more;
		logic out_free;
	} dp_sts_t;

	function automatic count_t sat_inc(input count_t c);
		return (c == '1) ? c : count_t'(c + count_t'(1));
	endfunction

endpackage

[rtl/srbc_ifs.sv]
// Valid/ready channel interfaces: point beats in, ranked result beats out.
// Depends on srbc_pkg for field widths.
interface srbc_pt_if;
	logic                           valid;
	logic                           ready;
	logic [srbc_pkg::SEG_IN_W-1:0]  segment_id;
	logic                           last_point;

	modport source (output valid, output segment_id, output last_point, input ready);
	modport sink   (input valid, input segment_id, input last_point, output ready);
endinterface

interface srbc_rank_if;
	logic                              valid;
	logic                              ready;
	logic [srbc_pkg::RANK_ID_W-1:0]    ranked_segment;
	logic [srbc_pkg::OUT_COUNT_W-1:0]  point_count;
	logic                              dropped_any;
	logic                              last_rank;

	modport source (output valid, output ranked_segment, output point_count,
		output dropped_any, output last_rank, input ready);
	modport sink   (input valid, input ranked_segment, input point_count,
		input dropped_any, input last_rank, output ready);
endinterface

[rtl/srbc_ctrl.sv]
// Controller state machine: counting, ranking passes, emit and clear.
// Depends on srbc_pkg for the state enum and command/status structs.
module srbc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  srbc_pkg::dp_sts_t sts,
	output srbc_pkg::dp_cmd_t cmd
);

	srbc_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srbc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srbc_pkg::ST_IDLE: begin
				if (in_valid && in_last) state_d = srbc_pkg::ST_DRAIN;
			end
			srbc_pkg::ST_DRAIN: state_d = srbc_pkg::ST_SCAN;
			srbc_pkg::ST_SCAN: begin
				if (sts.scan_last) state_d = srbc_pkg::ST_TAIL;
			end
			srbc_pkg::ST_TAIL: state_d = srbc_pkg::ST_EMIT;
			srbc_pkg::ST_EMIT: begin
				if (!sts.found) state_d = srbc_pkg::ST_CLEAR;
				else if (sts.out_free)
					state_d = sts.more ? srbc_pkg::ST_SCAN : srbc_pkg::ST_CLEAR;
			end
			srbc_pkg::ST_CLEAR: state_d = srbc_pkg::ST_IDLE;
			default: state_d = srbc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd            = '0;
		unique case (state_q)
			srbc_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.in_take = in_valid;
			end
			srbc_pkg::ST_DRAIN: cmd.scan_clr = 1'b1;
			srbc_pkg::ST_SCAN:  cmd.scan_en  = 1'b1;
			srbc_pkg::ST_TAIL: ;
			srbc_pkg::ST_EMIT: begin
				cmd.emit     = sts.found && sts.out_free;
				cmd.scan_clr = sts.found && sts.out_free && sts.more;
			end
			srbc_pkg::ST_CLEAR: cmd.hist_clear = 1'b1;
			default: ;
		endcase
	end

endmodule

[rtl/srbc_dp.sv]
// Datapath: histogram memory with increment pipeline, ranking scan, result register.
// Depends on srbc_pkg for widths, key type and command/status structs.
module srbc_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [srbc_pkg::NSEG_W-1:0]       cfg_wdata,
	input  logic [srbc_pkg::SEG_IN_W-1:0]     in_id,
	input  srbc_pkg::dp_cmd_t                 cmd,
	output srbc_pkg::dp_sts_t                 sts,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [srbc_pkg::RANK_ID_W-1:0]    out_segment,
	output logic [srbc_pkg::OUT_COUNT_W-1:0]  out_count,
	output logic                              out_dropped,
	output logic                              out_last
);

	srbc_pkg::count_t hist_mem [srbc_pkg::MAX_SEGMENTS];
	logic [srbc_pkg::MAX_SEGMENTS-1:0] hist_vld_q;

	logic [srbc_pkg::NSEG_W-1:0] num_seg_q;
	logic                        drop_q;

	logic               in_range;
	srbc_pkg::seg_idx_t rd_addr;
	srbc_pkg::count_t   rd_q;

	// increment pipeline
	logic               cnt_vld_s1;
	srbc_pkg::seg_idx_t cnt_id_s1;
	logic               fwd_vld_q;
	srbc_pkg::seg_idx_t fwd_id_q;
	srbc_pkg::count_t   fwd_val_q;
	srbc_pkg::count_t   cnt_base;
	srbc_pkg::count_t   cnt_new;

	// ranking scan
	srbc_pkg::seg_idx_t scan_idx_q;
	logic               cmp_vld_s1;
	srbc_pkg::seg_idx_t cmp_id_s1;
	logic               cmp_hv_s1;
	srbc_pkg::count_t   cmp_cnt;
	srbc_pkg::rank_key_t cmp_key;
	logic               cmp_listed;
	logic               cmp_cand;
	srbc_pkg::rank_key_t best_key_q;
	logic               found_q;
	logic               more_q;
	srbc_pkg::rank_key_t bound_key_q;
	logic               bound_ok_q;

	logic out_vld_q;

	assign in_range = ({1'b0, in_id} < (srbc_pkg::SEG_IN_W + 1)'(srbc_pkg::MAX_SEGMENTS));
	assign rd_addr  = cmd.scan_en ? scan_idx_q : in_id[srbc_pkg::ID_W-1:0];

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cnt_vld_s1) hist_mem[cnt_id_s1] <= cnt_new;
		rd_q <= hist_mem[rd_addr];
	end

	assign cnt_base = (fwd_vld_q && (fwd_id_q == cnt_id_s1)) ? fwd_val_q :
		(hist_vld_q[cnt_id_s1] ? rd_q : '0);
	assign cnt_new  = srbc_pkg::sat_inc(cnt_base);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_s1 <= 1'b0;
			fwd_vld_q  <= 1'b0;
			hist_vld_q <= '0;
			drop_q     <= 1'b0;
			num_seg_q  <= srbc_pkg::NSEG_RESET;
		end else begin
			cnt_vld_s1 <= cmd.in_take && in_range;
			fwd_vld_q  <= cnt_vld_s1;
			if (cfg_we) num_seg_q <= cfg_wdata;
			if (cmd.hist_clear) begin
				hist_vld_q <= '0;
				drop_q     <= 1'b0;
			end else begin
				if (cnt_vld_s1) hist_vld_q[cnt_id_s1] <= 1'b1;
				if (cmd.in_take && !in_range) drop_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cnt_id_s1 <= in_id[srbc_pkg::ID_W-1:0];
		fwd_id_q  <= cnt_id_s1;
		fwd_val_q <= cnt_new;
		cmp_id_s1 <= scan_idx_q;
		cmp_hv_s1 <= hist_vld_q[scan_idx_q];
	end

	// compare stage: best key strictly below the previous winner
	assign cmp_cnt    = cmp_hv_s1 ? rd_q : '0;
	assign cmp_key    = {cmp_cnt, cmp_id_s1};
	assign cmp_listed = (cmp_cnt != '0) || ((cmp_id_s1 != '0) &&
		({1'b0, cmp_id_s1} <= {1'b0, num_seg_q}));
	assign cmp_cand   = cmp_vld_s1 && cmp_listed && (!bound_ok_q || (cmp_key < bound_key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			more_q     <= 1'b0;
			bound_ok_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan_en;
			if (cmd.scan_clr) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
				more_q     <= 1'b0;
			end else begin
				if (cmd.scan_en) scan_idx_q <= srbc_pkg::seg_idx_t'(scan_idx_q + 1'b1);
				if (cmp_cand) begin
					found_q <= 1'b1;
					more_q  <= more_q | found_q;
				end
			end
			if (cmd.hist_clear) bound_ok_q <= 1'b0;
			else if (cmd.emit)  bound_ok_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_cand && (!found_q || (cmp_key > best_key_q))) best_key_q <= cmp_key;
		if (cmd.emit) bound_key_q <= best_key_q;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_segment <= srbc_pkg::RANK_ID_W'(best_key_q[srbc_pkg::ID_W-1:0]);
			out_count   <= srbc_pkg::OUT_COUNT_W'(best_key_q[srbc_pkg::KEY_W-1:srbc_pkg::ID_W]);
			out_dropped <= drop_q;
			out_last    <= !more_q;
		end
	end

	assign out_valid     = out_vld_q;
	assign sts.scan_last = (scan_idx_q == srbc_pkg::seg_idx_t'(srbc_pkg::MAX_SEGMENTS - 1));
	assign sts.found     = found_q;
	assign sts.more      = more_q;
	assign sts.out_free  = !out_vld_q || out_ready;

endmodule

[rtl/segment_rank_by_count_top.sv]
// Top level of the segment ranking block: wires controller and datapath to the channels.
// Depends on srbc_pkg, srbc_ifs, srbc_ctrl and srbc_dp.
//
//  channel  | dir | beat contents
//  ---------+-----+------------------------------------------------------------
//  points   | in  | segment_id, last_point
//  ranks    | out | ranked_segment, point_count, dropped_any, last_rank
//  cfg      | in  | cfg_we / cfg_wdata -> num_segments (no read-back)
//
// Counting takes one point beat per cycle; a read-modify-write pipeline on the
// histogram memory forwards back-to-back hits on the same id.
// A last point leads into a drain step, then each ranked result takes one full
// scan of the 64-entry histogram through its single read port, then a tail and
// an emit step, plus a clear step at the end of the run.
// The result register frees the next scan while a beat waits on ranks.ready;
// a stall only holds the emit step. Reset clears all counts and the drop flag.
module segment_rank_by_count_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [srbc_pkg::NSEG_W-1:0]   cfg_wdata,
	srbc_pt_if.sink                       points,
	srbc_rank_if.source                   ranks
);

	srbc_pkg::dp_cmd_t cmd;
	srbc_pkg::dp_sts_t sts;

	// controller: sequence counting, ranking passes and clear
	srbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (points.valid),
		.in_last  (points.last_point),
		.in_ready (points.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: histogram, scan compare, result register
	srbc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_id       (points.segment_id),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (ranks.ready),
		.out_valid   (ranks.valid),
		.out_segment (ranks.ranked_segment),
		.out_count   (ranks.point_count),
		.out_dropped (ranks.dropped_any),
		.out_last    (ranks.last_rank)
	);

`ifndef SYNTHESIS
	// a last point closes the input until the run is over
	a_last_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(points.valid && points.ready && points.last_point) |=> !points.ready)
		else $error("point beat taken right after a last point");

	// never overwrite a result that is still waiting
	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result register overwritten while full");

	// scan reads and point counting never share the memory port
	a_scan_vs_count: assert property (@(posedge clk) disable iff (!arst_n)
		(points.valid && points.ready) |-> !cmd.scan_en)
		else $error("scan read while taking a point beat");
`endif

endmodule
